>>> hw/rtl/pcx_rle_scanline_decoder_assert.svh
// Assertion macros for the checker of the PCX run-length decoder.
`ifndef PCX_RLE_SCANLINE_DECODER_ASSERT_SVH
`define PCX_RLE_SCANLINE_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PCX_ASSERT_IMPLIES(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("pcx_rle_scanline_decoder: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PCX_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("pcx_rle_scanline_decoder: next-cycle check failed");

`endif

>>> hw/rtl/pcxrle_pkg.sv
// Types and constants shared by the PCX run-length decoder modules.
package pcxrle_pkg;

   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 6;
   localparam int COL_W       = 10;
   localparam int PLANE_W     = 2;
   localparam int LINE_W      = 10;
   localparam int CFG_W       = 11;
   localparam int PC_W        = 3;
   localparam int CSR_INDEX_W = 2;

   localparam logic [BYTE_W-1:0]  RUN_MASK    = 8'hC0;
   localparam logic [BYTE_W-1:0]  COUNT_MASK  = 8'h3F;
   localparam logic [PC_W-1:0]    PLANE_LIMIT = 3'd4;
   localparam int                 COUNTER_SPAN = 1024;

   localparam logic [CFG_W-1:0] PLANE_BYTES_RESET   = 11'd80;
   localparam logic [PC_W-1:0]  PLANE_COUNT_RESET   = 3'd1;
   localparam logic [CFG_W-1:0] VISIBLE_BYTES_RESET = 11'd80;
   localparam logic [CFG_W-1:0] LINE_COUNT_RESET    = 11'd200;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PLANE_BYTES   = 2'd0,
      REG_PLANE_COUNT   = 2'd1,
      REG_VISIBLE_BYTES = 2'd2,
      REG_LINE_COUNT    = 2'd3
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // take the accepted request byte
      logic emit;   // produce one result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic start_run;  // the byte being offered starts a non-empty run
      logic run_done;   // the result being produced now ends the run
   } status_type;

endpackage

>>> hw/rtl/pcxrle_ctrl.sv
// Controller state machine of the PCX run-length decoder.
module pcxrle_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  pcxrle_pkg::status_type status,
   output pcxrle_pkg::cmd_type    cmd
);

   typedef enum logic {
      IDLE,
      RUN
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.start_run) begin
                  state_in = RUN;
               end
            end
         end
         RUN: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               if (status.run_done) begin
                  state_in = IDLE;
               end
            end
         end
      endcase
      req_ready_in = (state_in == IDLE);
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/pcxrle_dp.sv
// Datapath of the PCX run-length decoder: registers, counters and result register.
module pcxrle_dp #(
   parameter int MAX_PLANE_BYTES = 1024,
   parameter int MAX_LINES       = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [pcxrle_pkg::BYTE_W-1:0]          req_code_byte,
   input  logic                                   csr_write,
   input  logic [pcxrle_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pcxrle_pkg::CFG_W-1:0]           csr_wdata,
   input  pcxrle_pkg::cmd_type                    cmd,
   output pcxrle_pkg::status_type                 status,
   output logic [pcxrle_pkg::BYTE_W-1:0]          rsp_pixel_byte,
   output logic [pcxrle_pkg::PLANE_W-1:0]         rsp_plane,
   output logic [pcxrle_pkg::COL_W-1:0]           rsp_column,
   output logic                                   rsp_visible,
   output logic                                   rsp_line_end,
   output logic                                   rsp_image_end,
   output logic                                   rsp_run_last
);

   localparam int PB_CAP = (MAX_PLANE_BYTES < pcxrle_pkg::COUNTER_SPAN) ?
                           MAX_PLANE_BYTES : pcxrle_pkg::COUNTER_SPAN;
   localparam int LC_CAP = (MAX_LINES < pcxrle_pkg::COUNTER_SPAN) ?
                           MAX_LINES : pcxrle_pkg::COUNTER_SPAN;
   localparam logic [pcxrle_pkg::CFG_W-1:0] PB_CAP_V = pcxrle_pkg::CFG_W'(PB_CAP);
   localparam logic [pcxrle_pkg::CFG_W-1:0] LC_CAP_V = pcxrle_pkg::CFG_W'(LC_CAP);

   // Configuration registers.
   logic [pcxrle_pkg::CFG_W-1:0] plane_bytes_ff;
   logic [pcxrle_pkg::PC_W-1:0]  plane_count_ff;
   logic [pcxrle_pkg::CFG_W-1:0] visible_bytes_ff;
   logic [pcxrle_pkg::CFG_W-1:0] line_count_ff;

   // Decoder state.
   logic                           prefix_pending_ff;
   logic [pcxrle_pkg::COUNT_W-1:0] pending_count_ff;
   logic [pcxrle_pkg::COUNT_W-1:0] remaining_ff;
   logic [pcxrle_pkg::BYTE_W-1:0]  run_byte_ff;
   logic [pcxrle_pkg::COL_W-1:0]   column_ff, column_in;
   logic [pcxrle_pkg::PLANE_W-1:0] plane_ff, plane_in;
   logic [pcxrle_pkg::LINE_W-1:0]  line_ff, line_in;

   // Result register.
   logic [pcxrle_pkg::BYTE_W-1:0]  pixel_byte_ff;
   logic [pcxrle_pkg::PLANE_W-1:0] plane_out_ff;
   logic [pcxrle_pkg::COL_W-1:0]   column_out_ff;
   logic                           visible_ff, line_end_ff, image_end_ff, run_last_ff;

   logic [pcxrle_pkg::CFG_W-1:0]   pb_eff, lc_eff;
   logic [pcxrle_pkg::PC_W-1:0]    pc_eff;
   logic [pcxrle_pkg::COL_W-1:0]   col_lim;
   logic [pcxrle_pkg::PLANE_W-1:0] plane_lim;
   logic [pcxrle_pkg::LINE_W-1:0]  line_lim;
   logic col_last, plane_last, line_last, lend, iend, count_last, is_prefix, visible;

   always_comb begin
      if (plane_bytes_ff == '0) begin
         pb_eff = pcxrle_pkg::CFG_W'(1);
      end else if (plane_bytes_ff > PB_CAP_V) begin
         pb_eff = PB_CAP_V;
      end else begin
         pb_eff = plane_bytes_ff;
      end
      if (plane_count_ff == '0) begin
         pc_eff = pcxrle_pkg::PC_W'(1);
      end else if (plane_count_ff > pcxrle_pkg::PLANE_LIMIT) begin
         pc_eff = pcxrle_pkg::PLANE_LIMIT;
      end else begin
         pc_eff = plane_count_ff;
      end
      if (line_count_ff == '0) begin
         lc_eff = pcxrle_pkg::CFG_W'(1);
      end else if (line_count_ff > LC_CAP_V) begin
         lc_eff = LC_CAP_V;
      end else begin
         lc_eff = line_count_ff;
      end
   end

   assign col_lim   = pcxrle_pkg::COL_W'(pb_eff - pcxrle_pkg::CFG_W'(1));
   assign plane_lim = pcxrle_pkg::PLANE_W'(pc_eff - pcxrle_pkg::PC_W'(1));
   assign line_lim  = pcxrle_pkg::LINE_W'(lc_eff - pcxrle_pkg::CFG_W'(1));

   // A counter at or beyond its last position counts as last.
   assign col_last   = column_ff >= col_lim;
   assign plane_last = plane_ff >= plane_lim;
   assign line_last  = line_ff >= line_lim;
   assign lend       = col_last && plane_last;
   assign iend       = lend && line_last;
   assign count_last = remaining_ff == pcxrle_pkg::COUNT_W'(1);
   assign visible    = {1'b0, column_ff} < visible_bytes_ff;

   assign is_prefix = (req_code_byte & pcxrle_pkg::RUN_MASK) == pcxrle_pkg::RUN_MASK;

   assign status.start_run = prefix_pending_ff ? (pending_count_ff != '0) : !is_prefix;
   assign status.run_done  = lend || count_last;

   always_comb begin
      column_in = column_ff + pcxrle_pkg::COL_W'(1);
      plane_in  = plane_ff;
      line_in   = line_ff;
      if (col_last) begin
         column_in = '0;
         if (plane_last) begin
            plane_in = '0;
            line_in  = iend ? '0 : line_ff + pcxrle_pkg::LINE_W'(1);
         end else begin
            plane_in = plane_ff + pcxrle_pkg::PLANE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_bytes_ff    <= pcxrle_pkg::PLANE_BYTES_RESET;
         plane_count_ff    <= pcxrle_pkg::PLANE_COUNT_RESET;
         visible_bytes_ff  <= pcxrle_pkg::VISIBLE_BYTES_RESET;
         line_count_ff     <= pcxrle_pkg::LINE_COUNT_RESET;
         prefix_pending_ff <= 1'b0;
         pending_count_ff  <= '0;
         remaining_ff      <= '0;
         column_ff         <= '0;
         plane_ff          <= '0;
         line_ff           <= '0;
      end else begin
         if (csr_write) begin
            unique case (pcxrle_pkg::csr_index_type'(csr_index))
               pcxrle_pkg::REG_PLANE_BYTES:   plane_bytes_ff   <= csr_wdata;
               pcxrle_pkg::REG_PLANE_COUNT:   plane_count_ff   <= csr_wdata[pcxrle_pkg::PC_W-1:0];
               pcxrle_pkg::REG_VISIBLE_BYTES: visible_bytes_ff <= csr_wdata;
               pcxrle_pkg::REG_LINE_COUNT:    line_count_ff    <= csr_wdata;
            endcase
         end
         if (cmd.load) begin
            if (prefix_pending_ff) begin
               prefix_pending_ff <= 1'b0;
               pending_count_ff  <= '0;
               remaining_ff      <= pending_count_ff;
            end else if (is_prefix) begin
               prefix_pending_ff <= 1'b1;
               pending_count_ff  <= pcxrle_pkg::COUNT_W'(req_code_byte & pcxrle_pkg::COUNT_MASK);
            end else begin
               remaining_ff <= pcxrle_pkg::COUNT_W'(1);
            end
         end
         if (cmd.emit) begin
            remaining_ff <= remaining_ff - pcxrle_pkg::COUNT_W'(1);
            column_ff    <= column_in;
            plane_ff     <= plane_in;
            line_ff      <= line_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         run_byte_ff <= req_code_byte;
      end
      if (cmd.emit) begin
         pixel_byte_ff <= run_byte_ff;
         plane_out_ff  <= plane_ff;
         column_out_ff <= column_ff;
         visible_ff    <= visible;
         line_end_ff   <= lend;
         image_end_ff  <= iend;
         run_last_ff   <= lend || count_last;
      end
   end

   assign rsp_pixel_byte = pixel_byte_ff;
   assign rsp_plane      = plane_out_ff;
   assign rsp_column     = column_out_ff;
   assign rsp_visible    = visible_ff;
   assign rsp_line_end   = line_end_ff;
   assign rsp_image_end  = image_end_ff;
   assign rsp_run_last   = run_last_ff;

endmodule

>>> hw/rtl/pcx_rle_scanline_decoder.sv
// Top level of the PCX run-length scan line decoder.
//
// The request channel takes one byte of a PCX compressed stream per request.
// A byte with both top bits set is a run prefix: it produces no response, and
// the following request byte is repeated as many times as the prefix's low six
// bits say (a count of zero consumes the value byte and produces nothing).
// Any other byte is a literal and produces one response.
// Each response carries the decoded byte, its plane and column in the scan
// line, a visible flag, line end, image end, and run_last on the last response
// caused by a request. A run that reaches a line end stops there.
// A prefix request leaves the decoder idle and ready for the next byte. A
// literal or run value request is accepted in the idle state; the controller
// then issues its responses from the run state, one result per cycle into a
// single output register while that register is free, and takes no new
// request until the run ends. The first response follows the request's entry
// into the run state, and the next request is taken while the last response
// still waits in the output register. When the receiver stalls, the output
// register holds its response and the run pauses. Reset returns the config
// registers to defaults, clears the position counters and any pending prefix;
// payload registers are not reset. The csr_ channel is always ready.
module pcx_rle_scanline_decoder #(
   parameter int MAX_PLANE_BYTES = 1024,
   parameter int MAX_LINES       = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [pcxrle_pkg::BYTE_W-1:0]      req_code_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pcxrle_pkg::BYTE_W-1:0]      rsp_pixel_byte,
   output logic [pcxrle_pkg::PLANE_W-1:0]     rsp_plane,
   output logic [pcxrle_pkg::COL_W-1:0]       rsp_column,
   output logic                               rsp_visible,
   output logic                               rsp_line_end,
   output logic                               rsp_image_end,
   output logic                               rsp_run_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pcxrle_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pcxrle_pkg::CFG_W-1:0]       csr_wdata
);

   pcxrle_pkg::cmd_type    cmd;
   pcxrle_pkg::status_type status;

   // The user must write registers only while the decoder is idle; the block
   // does not enforce this, and the port accepts every write at once.
   assign csr_ready = 1'b1;

   pcxrle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcxrle_dp #(
      .MAX_PLANE_BYTES (MAX_PLANE_BYTES),
      .MAX_LINES       (MAX_LINES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_code_byte  (req_code_byte),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .status         (status),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_plane      (rsp_plane),
      .rsp_column     (rsp_column),
      .rsp_visible    (rsp_visible),
      .rsp_line_end   (rsp_line_end),
      .rsp_image_end  (rsp_image_end),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

>>> hw/rtl/pcxrle_checker.sv
// Port-level assertion checker for the PCX run-length decoder, with its bind.
`include "pcx_rle_scanline_decoder_assert.svh"

module pcxrle_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [pcxrle_pkg::BYTE_W-1:0]      req_code_byte,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [pcxrle_pkg::BYTE_W-1:0]      rsp_pixel_byte,
   input logic [pcxrle_pkg::PLANE_W-1:0]     rsp_plane,
   input logic [pcxrle_pkg::COL_W-1:0]       rsp_column,
   input logic                               rsp_visible,
   input logic                               rsp_line_end,
   input logic                               rsp_image_end,
   input logic                               rsp_run_last
);

   logic [pcxrle_pkg::BYTE_W+pcxrle_pkg::PLANE_W+pcxrle_pkg::COL_W+3:0] rsp_payload;

   assign rsp_payload = {rsp_pixel_byte, rsp_plane, rsp_column, rsp_visible,
                         rsp_line_end, rsp_image_end, rsp_run_last};

   // A waiting request keeps its byte.
   `PCX_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req_code_byte))

   // A stalled response keeps its payload.
   `PCX_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // A line end always closes the run of its request.
   `PCX_ASSERT_IMPLIES(a_line_end_last, rsp_valid && rsp_line_end, rsp_run_last)

   // Image end only comes with a line end.
   `PCX_ASSERT_IMPLIES(a_image_end_line, rsp_valid && rsp_image_end, rsp_line_end)

endmodule

bind pcx_rle_scanline_decoder pcxrle_checker u_checker (.*);
